// File: hw/rtl/tpag_pkg.sv
// Shared types and constants for the tensor permute address generator.
// No dependencies; every other file imports this package.
package tpag_pkg;

  localparam int AXES       = 4;
  localparam int AXIS_BITS  = 2;
  localparam int COUNT_BITS = 3;
  localparam int SIZE_BITS  = 16;
  localparam int INDEX_BITS = 32;
  localparam int MAP_BITS   = AXES * AXIS_BITS;
  localparam int PADDR_BITS = 5;
  localparam int PDATA_BITS = 32;

  typedef logic [SIZE_BITS-1:0] tsize_t;
  typedef logic [AXIS_BITS-1:0] axis_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MAP   = 2'd1,
    ERR_COUNT = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE_0    = 3'd1,
    REG_SIZE_1    = 3'd2,
    REG_SIZE_2    = 3'd3,
    REG_SIZE_3    = 3'd4,
    REG_AXIS_MAP  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  dim_count;
    tsize_t [AXES-1:0]      in_size;
    logic [MAP_BITS-1:0]    axis_map;
  } tpag_cfg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] axes_used;
    err_t                  err;
  } tpag_mode_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] src;
    logic [INDEX_BITS-1:0] dst;
    logic                  last;
    err_t                  err;
  } tpag_result_t;

  // One axis of size one, identity map
  localparam tpag_cfg_t CFG_RESET = '{
    dim_count: COUNT_BITS'(1),
    in_size:   {AXES{SIZE_BITS'(1)}},
    axis_map:  MAP_BITS'(8'hE4)
  };

endpackage

// File: hw/rtl/tpag_regs.sv
// Configuration register file behind the APB-style port.
// Depends on tpag_pkg.
module tpag_regs
  import tpag_pkg::*;
#(
  parameter int SIZE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output tpag_cfg_t             cfg,
  output logic                  cfg_wr
);

  localparam tsize_t SIZE_MASK = (SIZE_WIDTH >= SIZE_BITS) ? '1 :
                                 SIZE_BITS'((64'd1 << SIZE_WIDTH) - 64'd1);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (idx)
        REG_DIM_COUNT: cfg.dim_count  <= pwdata[COUNT_BITS-1:0];
        REG_SIZE_0:    cfg.in_size[0] <= pwdata[SIZE_BITS-1:0] & SIZE_MASK;
        REG_SIZE_1:    cfg.in_size[1] <= pwdata[SIZE_BITS-1:0] & SIZE_MASK;
        REG_SIZE_2:    cfg.in_size[2] <= pwdata[SIZE_BITS-1:0] & SIZE_MASK;
        REG_SIZE_3:    cfg.in_size[3] <= pwdata[SIZE_BITS-1:0] & SIZE_MASK;
        REG_AXIS_MAP:  cfg.axis_map   <= pwdata[MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DIM_COUNT: prdata = PDATA_BITS'(cfg.dim_count);
      REG_SIZE_0:    prdata = PDATA_BITS'(cfg.in_size[0]);
      REG_SIZE_1:    prdata = PDATA_BITS'(cfg.in_size[1]);
      REG_SIZE_2:    prdata = PDATA_BITS'(cfg.in_size[2]);
      REG_SIZE_3:    prdata = PDATA_BITS'(cfg.in_size[3]);
      REG_AXIS_MAP:  prdata = PDATA_BITS'(cfg.axis_map);
      default:       prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/tpag_setup.sv
// Setup sequencer: after reset or a register write, derives output sizes,
// per-axis source steps, error code and the address pair of the held position.
// Depends on tpag_pkg.
module tpag_setup
  import tpag_pkg::*;
#(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  tpag_cfg_t                           cfg,
  input  tsize_t [AXES-1:0]                   pos,
  output logic                                done,
  output logic                                load,
  output tpag_mode_t                          mode,
  output tsize_t [AXES-1:0]                   ysz,
  output logic [AXES-1:0][ADDR_WIDTH-1:0]     step,
  output logic [ADDR_WIDTH-1:0]               src_init,
  output logic [ADDR_WIDTH-1:0]               dst_init
);

  localparam int LAST_STEP  = 3 * AXES;
  localparam int STEP_BITS  = $clog2(LAST_STEP + 1);
  localparam int XACC_BITS  = ADDR_WIDTH + 1;
  localparam int XPROD_BITS = XACC_BITS + SIZE_BITS;

  logic                             busy;
  logic [STEP_BITS-1:0]             cnt;
  logic [XACC_BITS-1:0]             xacc;
  logic                             ovf;
  logic [ADDR_WIDTH-1:0]            yacc;
  logic [AXES-1:0][ADDR_WIDTH-1:0]  xstr;
  logic [AXES-1:0][ADDR_WIDTH-1:0]  ystr;
  logic [ADDR_WIDTH-1:0]            rsum;
  logic [ADDR_WIDTH-1:0]            xa_r;
  logic [ADDR_WIDTH-1:0]            prod_r;
  logic [ADDR_WIDTH-1:0]            srcp_r;
  logic [ADDR_WIDTH-1:0]            dstp_r;
  logic [ADDR_WIDTH-1:0]            src_acc;
  logic [ADDR_WIDTH-1:0]            dst_acc;

  logic [COUNT_BITS-1:0]  n_used;
  tsize_t [AXES-1:0]      s;
  axis_t [AXES-1:0]       ax;
  logic [AXES-1:0]        seen;
  logic                   map_bad;
  logic                   count_big;
  logic                   in_a;
  logic [STEP_BITS-1:0]   jb;
  axis_t                  k;
  logic                   sub;
  logic                   act;
  tsize_t                 ysz_k;
  logic [XPROD_BITS-1:0]  xprod;
  logic [ADDR_WIDTH-1:0]  yprod;
  logic [ADDR_WIDTH-1:0]  xa;
  tsize_t                 ysz_m1;

  // Clamp axis count, force zero sizes to one, unpack the map
  always_comb begin
    if (cfg.dim_count == '0) begin
      n_used = COUNT_BITS'(1);
    end else if (cfg.dim_count > COUNT_BITS'(AXES)) begin
      n_used = COUNT_BITS'(AXES);
    end else begin
      n_used = cfg.dim_count;
    end
    for (int i = 0; i < AXES; i++) begin
      s[i]  = (cfg.in_size[i] == '0) ? SIZE_BITS'(1) : cfg.in_size[i];
      ax[i] = cfg.axis_map[i*AXIS_BITS +: AXIS_BITS];
    end
  end

  // Check that the used map fields form a permutation
  always_comb begin
    seen    = '0;
    map_bad = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      if (COUNT_BITS'(i) < n_used) begin
        if (COUNT_BITS'(ax[i]) >= n_used || seen[ax[i]]) begin
          map_bad = 1'b1;
        end
        seen[ax[i]] = 1'b1;
      end
    end
  end

  // Element count beyond 2^ADDR_WIDTH
  assign count_big = ovf || (xacc[ADDR_WIDTH] && |xacc[ADDR_WIDTH-1:0]);

  // Decode the sequencer step: phase A walks axes top down once, phase B twice
  assign in_a = cnt < STEP_BITS'(AXES);
  assign jb   = cnt - STEP_BITS'(AXES);
  assign sub  = jb[0];
  assign k    = in_a ? axis_t'(STEP_BITS'(AXES - 1) - cnt)
                     : axis_t'(AXES - 1) - axis_t'(jb >> 1);
  assign act  = COUNT_BITS'(k) < n_used;

  // Phase A products: input strides, output strides
  assign ysz_k = s[ax[k]];
  assign xprod = XPROD_BITS'(xacc) * XPROD_BITS'(s[k]);
  assign yprod = yacc * ADDR_WIDTH'(ysz_k);

  // Phase B operands
  assign xa     = xstr[ax[k]];
  assign ysz_m1 = ysz[k] - SIZE_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      busy    <= 1'b1;
      cnt     <= '0;
      xacc    <= XACC_BITS'(1);
      ovf     <= 1'b0;
      yacc    <= ADDR_WIDTH'(1);
      rsum    <= '0;
      src_acc <= '0;
      dst_acc <= '0;
    end else if (busy) begin
      cnt <= cnt + STEP_BITS'(1);
      if (in_a) begin
        // Stride pass for one axis
        ysz[k] <= ysz_k;
        if (act) begin
          xstr[k] <= xacc[ADDR_WIDTH-1:0];
          ystr[k] <= yacc;
          xacc    <= xprod[XACC_BITS-1:0];
          yacc    <= yprod;
          if (|xprod[XPROD_BITS-1:XACC_BITS]) begin
            ovf <= 1'b1;
          end
        end
      end else if (cnt == STEP_BITS'(LAST_STEP)) begin
        // Finish: publish mode
        busy           <= 1'b0;
        mode.axes_used <= n_used;
        mode.err       <= map_bad ? ERR_MAP : (count_big ? ERR_COUNT : ERR_NONE);
      end else if (!sub) begin
        // Multiply rewind, source and destination terms
        xa_r   <= xa;
        prod_r <= xa * ADDR_WIDTH'(ysz_m1);
        srcp_r <= xa * ADDR_WIDTH'(pos[k]);
        dstp_r <= ystr[k] * ADDR_WIDTH'(pos[k]);
      end else if (act) begin
        // Step for a carry into axis k rewinds every faster axis
        step[k] <= xa_r - rsum;
        rsum    <= rsum + prod_r;
        src_acc <= src_acc + srcp_r;
        dst_acc <= dst_acc + dstp_r;
      end
    end
  end

  assign done     = !busy;
  assign load     = busy && (cnt == STEP_BITS'(LAST_STEP));
  assign src_init = src_acc;
  assign dst_init = dst_acc;

endmodule

// File: hw/rtl/tpag_walk.sv
// Position walker: while in_ready is high, one request per cycle updates
// the output coordinates and the address pair incrementally; results go
// out through a two-entry skid. Depends on tpag_pkg.
module tpag_walk
  import tpag_pkg::*;
#(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             done,
  input  logic                             load,
  input  tpag_mode_t                       mode,
  input  tsize_t [AXES-1:0]                ysz,
  input  logic [AXES-1:0][ADDR_WIDTH-1:0]  step,
  input  logic [ADDR_WIDTH-1:0]            src_init,
  input  logic [ADDR_WIDTH-1:0]            dst_init,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tpag_result_t                     out_res,
  output tsize_t [AXES-1:0]                pos
);

  logic                   started;
  logic [ADDR_WIDTH-1:0]  src;
  logic [ADDR_WIDTH-1:0]  dst;
  tpag_result_t           out_reg;
  tpag_result_t           skid_reg;
  logic                   skid_valid;

  logic                   fire;
  logic                   in_range;
  logic                   found;
  axis_t                  cidx;
  logic                   zero_pos;
  tsize_t [AXES-1:0]      pos_next;
  logic [ADDR_WIDTH-1:0]  src_next;
  logic [ADDR_WIDTH-1:0]  dst_next;
  logic                   last_next;
  tpag_result_t           res;

  assign in_ready = done && !skid_valid;
  assign fire     = in_valid && in_ready;

  // Position check and carry search, fastest (last) axis first
  always_comb begin
    in_range = 1'b1;
    found    = 1'b0;
    cidx     = '0;
    for (int i = 0; i < AXES; i++) begin
      if (COUNT_BITS'(i) < mode.axes_used) begin
        if (pos[i] >= ysz[i]) in_range = 1'b0;
      end else if (pos[i] != '0) begin
        in_range = 1'b0;
      end
    end
    for (int i = AXES - 1; i >= 0; i--) begin
      if (!found && COUNT_BITS'(i) < mode.axes_used &&
          ((SIZE_BITS+1)'(pos[i]) + (SIZE_BITS+1)'(1)) < (SIZE_BITS+1)'(ysz[i])) begin
        found = 1'b1;
        cidx  = axis_t'(i);
      end
    end
  end

  // Next position and addresses; back to the first element where needed
  always_comb begin
    zero_pos  = (mode.err != ERR_NONE) || restart || !started || !in_range || !found;
    last_next = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (zero_pos || axis_t'(i) > cidx) begin
        pos_next[i] = '0;
      end else if (axis_t'(i) == cidx) begin
        pos_next[i] = pos[i] + SIZE_BITS'(1);
      end else begin
        pos_next[i] = pos[i];
      end
    end
    for (int i = 0; i < AXES; i++) begin
      if (COUNT_BITS'(i) < mode.axes_used &&
          ((SIZE_BITS+1)'(pos_next[i]) + (SIZE_BITS+1)'(1)) != (SIZE_BITS+1)'(ysz[i])) begin
        last_next = 1'b0;
      end
    end
    src_next = zero_pos ? '0 : src + step[cidx];
    dst_next = zero_pos ? '0 : dst + ADDR_WIDTH'(1);
    if (mode.err != ERR_NONE) begin
      res = '{src: '0, dst: '0, last: 1'b0, err: mode.err};
    end else begin
      res = '{src: INDEX_BITS'(src_next), dst: INDEX_BITS'(dst_next),
              last: last_next, err: ERR_NONE};
    end
  end

  // Walk state: load after setup, advance on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      started <= 1'b0;
    end else if (load) begin
      src <= src_init;
      dst <= dst_init;
    end else if (fire) begin
      pos     <= pos_next;
      src     <= src_next;
      dst     <= dst_next;
      started <= (mode.err == ERR_NONE);
    end
  end

  // Output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (fire) begin
      if (!out_valid || out_ready) begin
        out_reg   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_res = out_reg;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_err_clears_walk: assert property (@(posedge clk) disable iff (rst)
    (fire && mode.err != ERR_NONE) |=> (!started && pos == '0))
    else $error("error request did not return to the first element");

  a_dst_steps_one: assert property (@(posedge clk) disable iff (rst)
    (fire && !zero_pos) |=> (dst == $past(dst) + ADDR_WIDTH'(1)))
    else $error("destination index did not advance by one");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.err != ERR_NONE) |->
      (out_reg.src == '0 && out_reg.dst == '0 && !out_reg.last))
    else $error("error result carries address fields");
`endif

endmodule

// File: hw/rtl/tensor_permute_address_generator_top.sv
// Top level of the tensor permute address generator.
// Depends on tpag_pkg, tpag_regs, tpag_setup and tpag_walk.
//
//   channel   handshake                       payload
//   in        in_valid / in_ready             restart
//   out       out_valid / out_ready           src_index, dst_index, last, error
//   cfg       psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// One request per cycle while in_ready is high; each result is registered in the
// output register, or in the skid entry while that entry is held; the walker updates
// coordinates and both indices by add-and-select only. After reset and after
// every register write a setup pass rebuilds strides and steps with one multiply
// per term; in_ready is low then. The two-entry output stage takes one more request
// while out_ready is low. Reset is synchronous and active high.
module tensor_permute_address_generator_top
  import tpag_pkg::*;
#(
  parameter int SIZE_WIDTH = 16,
  parameter int ADDR_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_BITS-1:0] src_index,
  output logic [INDEX_BITS-1:0] dst_index,
  output logic                  last,
  output logic [1:0]            error,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  tpag_cfg_t                        cfg;
  logic                             cfg_wr;
  logic                             done;
  logic                             load;
  tpag_mode_t                       mode;
  tsize_t [AXES-1:0]                ysz;
  logic [AXES-1:0][ADDR_WIDTH-1:0]  step;
  logic [ADDR_WIDTH-1:0]            src_init;
  logic [ADDR_WIDTH-1:0]            dst_init;
  tsize_t [AXES-1:0]                pos;
  tpag_result_t                     out_res;

  tpag_regs #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  tpag_setup #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_setup (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg      (cfg),
    .pos      (pos),
    .done     (done),
    .load     (load),
    .mode     (mode),
    .ysz      (ysz),
    .step     (step),
    .src_init (src_init),
    .dst_init (dst_init)
  );

  tpag_walk #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .done      (done),
    .load      (load),
    .mode      (mode),
    .ysz       (ysz),
    .step      (step),
    .src_init  (src_init),
    .dst_init  (dst_init),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .pos       (pos)
  );

  // Split the result into its ports
  assign src_index = out_res.src;
  assign dst_index = out_res.dst;
  assign last      = out_res.last;
  assign error     = out_res.err;

endmodule

// File: bench/tpag_addr_checker.sv
// Checker for the tensor permute address generator: follows register writes, predicts
// the address pair of every accepted request and compares it with the result channel.
// Depends on tpag_pkg for widths, error codes and register indexes.
module tpag_addr_checker
  import tpag_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  restart,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [INDEX_BITS-1:0] src_index,
  input  logic [INDEX_BITS-1:0] dst_index,
  input  logic                  last,
  input  logic [1:0]            error,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output int                    mismatches,
  output int                    pairs_due
);

  localparam int PRINT_CAP = 40;

  // shadow registers and walker state
  logic [COUNT_BITS-1:0] axes_reg;
  tsize_t                size_reg [AXES];
  logic [MAP_BITS-1:0]   map_reg;
  tsize_t                pos [AXES];
  logic                  walk_started;

  tpag_result_t          due_pairs [$];

  // Step the walker by one request and return the address pair it yields
  function automatic tpag_result_t next_address(input logic restart_req);
    tpag_result_t    res;
    int unsigned     n;
    int unsigned     ax [AXES];
    longint unsigned sz [AXES];
    longint unsigned osz [AXES];
    longint unsigned istride [AXES];
    longint unsigned ostride [AXES];
    longint unsigned count, src_sum, dst_sum, p;
    logic [AXES-1:0] seen;
    err_t            code;
    logic            in_bounds, at_end;

    res  = '0;
    code = ERR_NONE;
    n = (axes_reg == 0) ? 1 : ((axes_reg > AXES) ? AXES : axes_reg);
    for (int i = 0; i < AXES; i++) begin
      sz[i] = (size_reg[i] == 0) ? 1 : size_reg[i];
      ax[i] = map_reg[2*i +: 2];
    end

    // map must name every used axis exactly once
    seen = '0;
    for (int i = 0; i < n; i++) begin
      if (ax[i] >= n || seen[ax[i]]) code = ERR_MAP;
      seen[ax[i]] = 1'b1;
    end
    if (code == ERR_NONE) begin
      count = 1;
      for (int i = 0; i < n; i++) count = count * sz[i];
      if (count - 1 > 64'hFFFF_FFFF) code = ERR_COUNT;
    end
    if (code != ERR_NONE) begin
      for (int i = 0; i < AXES; i++) pos[i] = '0;
      walk_started = 1'b0;
      res.err = code;
      return res;
    end

    for (int i = 0; i < n; i++) osz[i] = sz[ax[i]];
    istride[n-1] = 1;
    ostride[n-1] = 1;
    for (int i = n - 1; i > 0; i--) begin
      istride[i-1] = istride[i] * sz[i];
      ostride[i-1] = ostride[i] * osz[i];
    end

    in_bounds = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (i < n) begin
        if (pos[i] >= osz[i]) in_bounds = 1'b0;
      end else if (pos[i] != 0) begin
        in_bounds = 1'b0;
      end
    end

    // restart, first request, or stale position: go to the first element
    if (restart_req || !walk_started || !in_bounds) begin
      for (int i = 0; i < AXES; i++) pos[i] = '0;
    end else begin
      for (int k = n - 1; k >= 0; k--) begin
        p = pos[k];
        if (p + 1 >= osz[k]) begin
          pos[k] = '0;
        end else begin
          pos[k] = pos[k] + 1'b1;
          break;
        end
      end
    end
    walk_started = 1'b1;

    src_sum = 0;
    dst_sum = 0;
    at_end  = 1'b1;
    for (int i = 0; i < n; i++) begin
      p = pos[i];
      dst_sum += p * ostride[i];
      src_sum += p * istride[ax[i]];
      if (p + 1 != osz[i]) at_end = 1'b0;
    end
    res.src  = src_sum[INDEX_BITS-1:0];
    res.dst  = dst_sum[INDEX_BITS-1:0];
    res.last = at_end;
    res.err  = ERR_NONE;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Watch the three ports at every rising edge
  always @(posedge clk) begin : watch
    tpag_result_t want;
    if (rst) begin
      axes_reg     = 3'd1;
      for (int i = 0; i < AXES; i++) begin
        size_reg[i] = 16'd1;
        pos[i]      = '0;
      end
      map_reg      = 8'hE4;
      walk_started = 1'b0;
      mismatches   = 0;
      due_pairs.delete();
    end else begin
      // follow register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_BITS-1:2])
          REG_DIM_COUNT: axes_reg    = pwdata[COUNT_BITS-1:0];
          REG_SIZE_0:    size_reg[0] = pwdata[SIZE_BITS-1:0];
          REG_SIZE_1:    size_reg[1] = pwdata[SIZE_BITS-1:0];
          REG_SIZE_2:    size_reg[2] = pwdata[SIZE_BITS-1:0];
          REG_SIZE_3:    size_reg[3] = pwdata[SIZE_BITS-1:0];
          REG_AXIS_MAP:  map_reg     = pwdata[MAP_BITS-1:0];
          default: ;
        endcase
      end
      // compare a delivered result with the oldest prediction
      if (out_valid && out_ready) begin
        if (due_pairs.size() == 0) begin
          report_mismatch("result with no request pending", src_index, 0);
        end else begin
          want = due_pairs.pop_front();
          if (src_index !== want.src) report_mismatch("src_index", src_index, want.src);
          if (dst_index !== want.dst) report_mismatch("dst_index", dst_index, want.dst);
          if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
          if (error !== want.err) report_mismatch("error", 32'(error), 32'(want.err));
        end
      end
      // predict for an accepted request
      if (in_valid && in_ready) due_pairs.insert(due_pairs.size(), next_address(restart));
    end
    pairs_due = due_pairs.size();
  end

endmodule

// File: bench/tensor_permute_address_generator_top_tb.sv
// Testbench top for the tensor permute address generator: clock, reset, register
// setup, request stimulus, result back-pressure and the verdict.
// Depends on tpag_pkg, tpag_addr_checker and tensor_permute_address_generator_top.
module tensor_permute_address_generator_top_tb;
  import tpag_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 1700;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  restart;
  logic                  out_valid;
  logic                  out_ready;
  logic [INDEX_BITS-1:0] src_index;
  logic [INDEX_BITS-1:0] dst_index;
  logic                  last;
  logic [1:0]            error;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  int                    mismatches;
  int                    pairs_due;
  int                    snd_idle_pct = 0;
  int                    rcv_idle_pct = 0;
  bit                    hold_go = 1'b0;
  int unsigned           cycle_count = 0;

  tensor_permute_address_generator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .src_index (src_index),
    .dst_index (dst_index),
    .last      (last),
    .error     (error),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tpag_addr_checker u_addr_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .src_index  (src_index),
    .dst_index  (dst_index),
    .last       (last),
    .error      (error),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pairs_due  (pairs_due)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // End the run if it hangs
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one request and return at the falling edge after it is taken
  task automatic send_request(input logic restart_req);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(1, 0));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (pairs_due != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle; junk above the field
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value, input int width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (value & mask) | ($urandom & ~mask);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // Program a full tensor shape while the block is idle
  task automatic program_shape(input logic [2:0] dims, input tsize_t s0, input tsize_t s1,
                               input tsize_t s2, input tsize_t s3, input logic [7:0] map);
    drain();
    write_reg(REG_DIM_COUNT, dims, COUNT_BITS);
    write_reg(REG_SIZE_0, s0, SIZE_BITS);
    write_reg(REG_SIZE_1, s1, SIZE_BITS);
    write_reg(REG_SIZE_2, s2, SIZE_BITS);
    write_reg(REG_SIZE_3, s3, SIZE_BITS);
    write_reg(REG_AXIS_MAP, map, MAP_BITS);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic tsize_t pick_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 88) return tsize_t'($urandom_range(4, 1));
    if (roll < 92) return '0;
    if (roll < 96) return 16'hFFFF;
    return tsize_t'($urandom);
  endfunction

  // Mostly small permuted shapes; now and then odd counts, big sizes, bad maps
  task automatic random_shape;
    int unsigned dims, n, tmp, j;
    int unsigned perm [AXES];
    logic [7:0]  map;
    dims = ($urandom_range(99) < 90) ? $urandom_range(AXES, 1) : $urandom_range(7, 5);
    if ($urandom_range(99) < 3) dims = 0;
    n = (dims == 0) ? 1 : ((dims > AXES) ? AXES : dims);
    for (int i = 0; i < AXES; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < AXES; i++)
      map[2*i +: 2] = (i < n) ? perm[i][1:0] : 2'($urandom_range(3, 0));
    if ($urandom_range(99) < 10) map = 8'($urandom);
    program_shape(dims[2:0], pick_size(), pick_size(), pick_size(), pick_size(), map);
  endtask

  // Stimulus
  initial begin : stimulus
    int sent, batch, phase_end;
    rst      = 1'b1;
    in_valid = 1'b0;
    restart  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset shape: single element, every request is the last one
    send_request(1'b0);
    send_request(1'b0);
    // four axes with a mixed permutation, restart in the middle
    program_shape(3'd4, 16'd2, 16'd3, 16'd1, 16'd2, 8'h87);
    repeat (6) send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    // repeated axis in the map
    program_shape(3'd3, 16'd2, 16'd2, 16'd2, 16'd1, 8'h20);
    send_request(1'b0);
    // map names an axis beyond the count in use
    program_shape(3'd2, 16'd3, 16'd4, 16'd1, 16'd1, 8'h07);
    send_request(1'b0);
    // element count beyond the address range
    program_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hE4);
    send_request(1'b0);
    // bad map wins over an oversized count
    program_shape(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
    send_request(1'b0);
    // axis count zero and size zero both act as one; first request after an error
    program_shape(3'd0, 16'd0, 16'd5, 16'd1, 16'd1, 8'hFC);
    repeat (2) send_request(1'b0);
    // axis count above four is clamped, reversed axes
    program_shape(3'd7, 16'd2, 16'd2, 16'd2, 16'd3, 8'h1B);
    repeat (3) send_request(1'b0);
    // largest sizes that still fit, swapped axes, unused map fields ignored
    program_shape(3'd2, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'hE1);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    // shrink so the current position falls outside the tensor
    program_shape(3'd2, 16'd2, 16'd2, 16'd1, 16'd1, 8'hE1);
    send_request(1'b0);

    // random part in three idling phases
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 31;
          rcv_idle_pct = 83;
        end
        1: begin
          snd_idle_pct = 83;
          rcv_idle_pct = 31;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      phase_end = (RANDOM_ITEMS * (phase + 1)) / 3;
      while (sent < phase_end) begin
        random_shape();
        batch = $urandom_range(90, 20);
        for (int i = 0; i < batch; i++) begin
          // long result hold-off while requests keep coming
          if (phase == 2 && i == 5) hold_go = 1'b1;
          send_request($urandom_range(99) < 4);
          sent++;
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
